// ----- rtl/fba_pkg.sv -----
// Shared types and constants for the block allocator.
`default_nettype none
package fba_pkg;

  localparam int TOTAL_W = 13;
  localparam int INDEX_W = 12;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

  // block map entry codes
  localparam logic [1:0] BLK_FREE     = 2'd0;
  localparam logic [1:0] BLK_ALLOC    = 2'd1;
  localparam logic [1:0] BLK_RESERVED = 2'd2;

  // request codes
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_FORMAT = 2'd2;

  // result status codes
  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_NONE  = 2'd1;
  localparam logic [1:0] RES_RANGE = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FORMAT
  } state_t;

  typedef enum logic [1:0] {
    WA_SWEEP,
    WA_HIT,
    WA_REQ
  } wsrc_t;

  typedef enum logic [1:0] {
    WD_FREE,
    WD_ALLOC,
    WD_FORMAT
  } wdata_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_CLR,
    CNT_FMT,
    CNT_DEC,
    CNT_INC
  } cnt_op_t;

  typedef struct packed {
    logic       addr_clr;
    logic       addr_inc;
    logic       rd_en;
    logic       we;
    wsrc_t      wsrc;
    wdata_t     wdata;
    cnt_op_t    cnt_op;
    logic       res_strobe;
    logic [1:0] res_status;
    logic       res_grant;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic rd_pending;
    logic addr_lt_total;
    logic sweep_last;
    logic idx_in_range;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/fat_block_allocator.sv -----
// Top level of the first-fit block allocator: controller plus datapath.
//
//   channel  handshake             payload
//   in       start / busy          in_req_type, in_block_index
//   out      out_valid (1 cycle)   out_status, out_allocated_block, out_free_count
//   cfg      cfg_wr_en             cfg_wr_data (total blocks)
//
// Free and unused requests are answered straight from idle; allocate scans the map,
// one map entry per cycle through the single read port of the block map.
// Format sweeps the whole map, one write per cycle.
// After reset the whole map is cleared with busy held high.
// The result shows in the cycle after the last work cycle; the receiver cannot stall.
`default_nettype none
module fat_block_allocator #(
  parameter int NUM_BLOCKS              = 4096,
  parameter int ENTRIES_PER_TABLE_BLOCK = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_req_type,
  input  wire logic [fba_pkg::INDEX_W-1:0] in_block_index,
  input  wire logic                        cfg_wr_en,
  input  wire logic [fba_pkg::TOTAL_W-1:0] cfg_wr_data,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [fba_pkg::INDEX_W-1:0]      out_allocated_block,
  output logic [fba_pkg::TOTAL_W-1:0]      out_free_count
);

  fba_pkg::ctrl_cmd_t cmd;
  fba_pkg::dp_stat_t  stat;

  fba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  fba_datapath #(
    .NUM_BLOCKS              (NUM_BLOCKS),
    .ENTRIES_PER_TABLE_BLOCK (ENTRIES_PER_TABLE_BLOCK)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_block_index      (in_block_index),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_allocated_block (out_allocated_block),
    .out_free_count      (out_free_count)
  );

endmodule
`default_nettype wire

// ----- rtl/fba_ctrl.sv -----
// Controller state machine for the block allocator.
`default_nettype none
module fba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        in_req_type,
  input  wire fba_pkg::dp_stat_t stat,
  output fba_pkg::ctrl_cmd_t     cmd,
  output logic                   busy
);

  fba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fba_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fba_pkg::ST_CLEAR: begin
        if (stat.sweep_last) state_nxt = fba_pkg::ST_IDLE;
      end
      fba_pkg::ST_IDLE: begin
        if (start) begin
          if (in_req_type == fba_pkg::REQ_ALLOC) state_nxt = fba_pkg::ST_SCAN;
          else if (in_req_type == fba_pkg::REQ_FORMAT) state_nxt = fba_pkg::ST_FORMAT;
        end
      end
      fba_pkg::ST_SCAN: begin
        if (stat.hit || (!stat.addr_lt_total && !stat.rd_pending)) begin
          state_nxt = fba_pkg::ST_IDLE;
        end
      end
      fba_pkg::ST_FORMAT: begin
        if (stat.sweep_last) state_nxt = fba_pkg::ST_IDLE;
      end
      default: state_nxt = fba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.wsrc       = fba_pkg::WA_SWEEP;
    cmd.wdata      = fba_pkg::WD_FREE;
    cmd.cnt_op     = fba_pkg::CNT_HOLD;
    cmd.res_status = fba_pkg::RES_OK;
    busy           = 1'b1;
    case (state_r)
      fba_pkg::ST_CLEAR: begin
        cmd.we       = 1'b1;
        cmd.addr_inc = 1'b1;
      end
      fba_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (in_req_type)
            fba_pkg::REQ_ALLOC: begin
              cmd.addr_clr = 1'b1;
            end
            fba_pkg::REQ_FREE: begin
              cmd.res_strobe = 1'b1;
              if (stat.idx_in_range) begin
                cmd.we     = 1'b1;
                cmd.wsrc   = fba_pkg::WA_REQ;
                cmd.cnt_op = fba_pkg::CNT_INC;
              end else begin
                cmd.res_status = fba_pkg::RES_RANGE;
              end
            end
            fba_pkg::REQ_FORMAT: begin
              cmd.addr_clr = 1'b1;
              cmd.cnt_op   = fba_pkg::CNT_CLR;
            end
            default: begin
              cmd.res_strobe = 1'b1;
            end
          endcase
        end
      end
      fba_pkg::ST_SCAN: begin
        if (stat.hit) begin
          // claim the first free entry seen
          cmd.we         = 1'b1;
          cmd.wsrc       = fba_pkg::WA_HIT;
          cmd.wdata      = fba_pkg::WD_ALLOC;
          cmd.cnt_op     = fba_pkg::CNT_DEC;
          cmd.res_strobe = 1'b1;
          cmd.res_grant  = 1'b1;
        end else if (stat.addr_lt_total) begin
          cmd.rd_en    = 1'b1;
          cmd.addr_inc = 1'b1;
        end else if (!stat.rd_pending) begin
          cmd.res_strobe = 1'b1;
          cmd.res_status = fba_pkg::RES_NONE;
        end
      end
      fba_pkg::ST_FORMAT: begin
        cmd.we         = 1'b1;
        cmd.wdata      = fba_pkg::WD_FORMAT;
        cmd.cnt_op     = fba_pkg::CNT_FMT;
        cmd.addr_inc   = 1'b1;
        cmd.res_strobe = stat.sweep_last;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/fba_datapath.sv -----
// Block map memory, address walker, free counter and result registers.
`default_nettype none
module fba_datapath #(
  parameter int NUM_BLOCKS              = 4096,
  parameter int ENTRIES_PER_TABLE_BLOCK = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [fba_pkg::INDEX_W-1:0]    in_block_index,
  input  wire logic                           cfg_wr_en,
  input  wire logic [fba_pkg::TOTAL_W-1:0]    cfg_wr_data,
  input  wire fba_pkg::ctrl_cmd_t             cmd,
  output fba_pkg::dp_stat_t                   stat,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [fba_pkg::INDEX_W-1:0]         out_allocated_block,
  output logic [fba_pkg::TOTAL_W-1:0]         out_free_count
);

  localparam int ADDR_W = $clog2(NUM_BLOCKS);
  localparam int CMP_W  = (ADDR_W + 1 > fba_pkg::TOTAL_W) ? ADDR_W + 1 : fba_pkg::TOTAL_W;
  localparam int PROD_W = fba_pkg::TOTAL_W + 1;
  localparam logic [ADDR_W:0]   LAST_ADDR = (ADDR_W + 1)'(NUM_BLOCKS - 1);
  localparam logic [PROD_W-1:0] TBL_STEP  = PROD_W'(ENTRIES_PER_TABLE_BLOCK);

  logic [fba_pkg::TOTAL_W-1:0] total_r;
  logic [fba_pkg::TOTAL_W-1:0] eff;
  logic [ADDR_W:0]             addr_r;
  logic [PROD_W-1:0]           prod_r;
  logic [fba_pkg::TOTAL_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]           rd_addr_r;
  logic                        rd_valid_r;
  logic [1:0]                  rdata_r;
  logic [1:0]                  map_mem [NUM_BLOCKS];
  logic [ADDR_W-1:0]           waddr;
  logic [1:0]                  wdata;
  logic                        addr_lt_eff;
  logic                        reserved;
  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [fba_pkg::INDEX_W-1:0] out_block_r;
  logic [fba_pkg::TOTAL_W-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= fba_pkg::TOTAL_RESET;
    end else if (cfg_wr_en) begin
      total_r <= cfg_wr_data;
    end
  end

  // cap the volume size at the map depth
  assign eff = (32'(total_r) > NUM_BLOCKS) ? fba_pkg::TOTAL_W'(NUM_BLOCKS) : total_r;

  assign addr_lt_eff = CMP_W'(addr_r) < CMP_W'(eff);
  // blocks 0 and 1 plus one per table block: b reserved while (b-2)*E < eff (capped total)
  assign reserved    = (addr_r < (ADDR_W + 1)'(2)) || (prod_r < PROD_W'(eff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= '0;
      prod_r     <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.rd_en;
      if (cmd.addr_clr) begin
        addr_r <= '0;
        prod_r <= '0;
      end else if (cmd.addr_inc) begin
        addr_r <= addr_r + (ADDR_W + 1)'(1);
        if (cmd.cnt_op == fba_pkg::CNT_FMT && !(addr_r < (ADDR_W + 1)'(2))
            && prod_r < PROD_W'(eff)) begin
          prod_r <= prod_r + TBL_STEP;
        end
      end
    end
  end

  always_comb begin
    case (cmd.wsrc)
      fba_pkg::WA_HIT: waddr = rd_addr_r;
      fba_pkg::WA_REQ: waddr = ADDR_W'(in_block_index);
      default:         waddr = addr_r[ADDR_W-1:0];
    endcase
    case (cmd.wdata)
      fba_pkg::WD_ALLOC:  wdata = fba_pkg::BLK_ALLOC;
      fba_pkg::WD_FORMAT: wdata = reserved ? fba_pkg::BLK_RESERVED : fba_pkg::BLK_FREE;
      default:            wdata = fba_pkg::BLK_FREE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      map_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r   <= map_mem[addr_r[ADDR_W-1:0]];
      rd_addr_r <= addr_r[ADDR_W-1:0];
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      fba_pkg::CNT_CLR: cnt_nxt = '0;
      fba_pkg::CNT_FMT: cnt_nxt = (addr_lt_eff && !reserved) ?
                                  cnt_r + fba_pkg::TOTAL_W'(1) : cnt_r;
      fba_pkg::CNT_DEC: cnt_nxt = (cnt_r != '0) ? cnt_r - fba_pkg::TOTAL_W'(1) : cnt_r;
      fba_pkg::CNT_INC: cnt_nxt = (cnt_r < eff) ? cnt_r + fba_pkg::TOTAL_W'(1) : eff;
      default:          cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd.res_strobe;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_strobe) begin
      out_status_r <= cmd.res_status;
      out_block_r  <= cmd.res_grant ? fba_pkg::INDEX_W'(rd_addr_r) : '0;
      out_count_r  <= cnt_nxt;
    end
  end

  assign stat.hit           = rd_valid_r && (rdata_r == fba_pkg::BLK_FREE);
  assign stat.rd_pending    = rd_valid_r;
  assign stat.addr_lt_total = addr_lt_eff;
  assign stat.sweep_last    = (addr_r == LAST_ADDR);
  assign stat.idx_in_range  = {1'b0, in_block_index} < eff;

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_allocated_block = out_block_r;
  assign out_free_count      = out_count_r;

endmodule
`default_nettype wire
